FILE: sv/kpc_pkg.sv
// Shared types, key codes and constants for the keypad add/subtract calculator.
`default_nettype none

package kpc_pkg;

    // Number of entry digits a user may key in (1 to 4).
    localparam int DIGIT_COUNT = 4;
    // Number of displayed decimal digits.
    localparam int SHOWN_DIGITS = 4;
    localparam int COUNT_W = $clog2(DIGIT_COUNT + 1);

    localparam int SUM_W = 16;
    localparam int VAL_W = 14;   // holds 0..9999
    localparam int MAX_DIGIT = 9;

    // Fixed-point reciprocals for splitting a value below ten thousand.
    // The divide by 1000 needs a finer scale to stay exact up to 9999.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_10 = 104858;
    localparam int RECIP_100 = 10486;
    localparam int RECIP_SHIFT_1000 = 24;
    localparam int RECIP_1000 = 16778;
    localparam int PROD_W = 31;

    typedef logic [3:0] digit_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        KIND_DIGIT       = 3'd0,
        KIND_ADD         = 3'd1,
        KIND_SUB         = 3'd2,
        KIND_EQUALS      = 3'd3,
        KIND_CLEAR_ALL   = 3'd4,
        KIND_CLEAR_ENTRY = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_RESULT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_NONE = 2'd2
    } op_t;

    // What travels down the display pipeline with each item.
    typedef struct packed {
        digit_t [SHOWN_DIGITS-1:0] entry;
        logic                      show_sum;
        logic                      result;
        sum_t                      sum;
    } disp_t;

endpackage

`default_nettype wire

FILE: sv/keypad_add_sub_calculator.sv
// Top level of the keypad add/subtract calculator: key event in, display item out.
`default_nettype none

// Path: a result item shows on out_valid once its accepted key event has passed the
//   input register, state update, modulo ten thousand, reciprocal split and output register.
// Throughput: one key event per cycle while the output is not stalled; the state update
//   from the input register feeds the calculator state, and each later stage holds one item.
// Reset (rst_n low, asynchronous): entry and sum zero, first-operand phase, no pending
//   operation, all pipeline stages empty.
module keypad_add_sub_calculator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic [3:0]         digit_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              shown_ones,
    output logic [3:0]              shown_tens,
    output logic [3:0]              shown_hundreds,
    output logic [3:0]              shown_thousands,
    output logic                    shown_negative,
    output logic                    showing_result,
    output logic signed [15:0]      accumulator
);

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain. Each stage moves on when the
    // next one is empty or moving, so bubbles close up under a stalled output.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, vout_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic adv0, adv1, adv2, adv3;

    assign rdy4     = !vout_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = !v0_reg || rdy1;

    assign adv0 = v0_reg && rdy1;
    assign adv1 = v1_reg && rdy2;
    assign adv2 = v2_reg && rdy3;
    assign adv3 = v3_reg && rdy4;

    // ------------------------------------------------------------------
    // Input register: hold the accepted key event.
    // ------------------------------------------------------------------
    kpc_pkg::kind_t  kind_reg;
    kpc_pkg::digit_t dval_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kpc_pkg::kind_t'(kind);
            dval_reg <= digit_value;
        end
    end

    // ------------------------------------------------------------------
    // Calculator state. It doubles as the stage-1 payload: the state after
    // an item is exactly what that item must display.
    // ------------------------------------------------------------------
    kpc_pkg::digit_t [kpc_pkg::SHOWN_DIGITS-1:0] entry_reg, entry_next;
    kpc_pkg::count_t count_reg, count_next;
    kpc_pkg::sum_t   sum_reg, sum_next;
    kpc_pkg::phase_t phase_reg, phase_next;
    kpc_pkg::op_t    op_reg, op_next;
    logic            show_reg, show_next;   // display comes from the sum

    // A function key or digit in result phase starts from a cleared entry.
    logic                                        in_result;
    kpc_pkg::digit_t [kpc_pkg::SHOWN_DIGITS-1:0] entry_base;
    kpc_pkg::count_t                             count_base;
    kpc_pkg::val_t                               operand;
    kpc_pkg::sum_t                               sum_plus, sum_minus, sum_fold;
    kpc_pkg::digit_t                             dval_sat;

    assign in_result  = (phase_reg == kpc_pkg::PHASE_RESULT);
    assign entry_base = in_result ? '0 : entry_reg;
    assign count_base = (in_result && kind_reg == kpc_pkg::KIND_DIGIT) ? '0 : count_reg;
    assign dval_sat   = (dval_reg > kpc_pkg::digit_t'(kpc_pkg::MAX_DIGIT))
                      ? kpc_pkg::digit_t'(kpc_pkg::MAX_DIGIT) : dval_reg;

    // Binary value of the entry: a few constant shift-adds.
    assign operand = kpc_pkg::val_t'(entry_base[0])
                   + kpc_pkg::val_t'(entry_base[1]) * kpc_pkg::val_t'(10)
                   + kpc_pkg::val_t'(entry_base[2]) * kpc_pkg::val_t'(100)
                   + kpc_pkg::val_t'(entry_base[3]) * kpc_pkg::val_t'(1000);

    assign sum_plus  = sum_reg + kpc_pkg::sum_t'(operand);
    assign sum_minus = sum_reg - kpc_pkg::sum_t'(operand);
    // In second-operand phase, plus and minus apply the operation armed by the previous key; else they add.
    assign sum_fold  = (phase_reg == kpc_pkg::PHASE_SECOND && op_reg == kpc_pkg::OP_SUB)
                     ? sum_minus : sum_plus;

    // Phase transitions.
    always_comb
    begin
        phase_next = phase_reg;
        case (kind_reg)
            kpc_pkg::KIND_DIGIT:
            begin
                if (in_result)
                    phase_next = kpc_pkg::PHASE_FIRST;
            end
            kpc_pkg::KIND_ADD, kpc_pkg::KIND_SUB:
                phase_next = kpc_pkg::PHASE_SECOND;
            kpc_pkg::KIND_EQUALS:
            begin
                if (op_reg == kpc_pkg::OP_ADD || op_reg == kpc_pkg::OP_SUB)
                    phase_next = kpc_pkg::PHASE_RESULT;
            end
            kpc_pkg::KIND_CLEAR_ALL:
                phase_next = kpc_pkg::PHASE_FIRST;
            default:
                phase_next = phase_reg;
        endcase
    end

    // Entry, count, sum, pending operation and display source.
    always_comb
    begin
        entry_next = entry_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        op_next    = op_reg;
        show_next  = show_reg;
        case (kind_reg)
            kpc_pkg::KIND_DIGIT:
            begin
                entry_next = entry_base;
                count_next = count_base;
                if (in_result)
                begin
                    show_next = 1'b0;
                    sum_next  = '0;
                end
                // Shift the entry left; drop digits beyond the limit.
                if (count_base < kpc_pkg::count_t'(kpc_pkg::DIGIT_COUNT))
                begin
                    for (int i = 1; i < kpc_pkg::SHOWN_DIGITS; i++)
                    begin
                        if (i <= int'(count_base))
                            entry_next[i] = entry_base[i-1];
                    end
                    entry_next[0] = dval_sat;
                    count_next    = kpc_pkg::count_t'(count_base + 1'b1);
                    show_next     = 1'b0;
                end
            end
            kpc_pkg::KIND_ADD, kpc_pkg::KIND_SUB:
            begin
                sum_next   = sum_fold;
                op_next    = (kind_reg == kpc_pkg::KIND_ADD) ? kpc_pkg::OP_ADD
                                                              : kpc_pkg::OP_SUB;
                count_next = '0;
                entry_next = '0;
                show_next  = 1'b0;
            end
            kpc_pkg::KIND_EQUALS:
            begin
                entry_next = entry_base;
                if (in_result)
                    show_next = 1'b0;
                if (op_reg == kpc_pkg::OP_ADD || op_reg == kpc_pkg::OP_SUB)
                begin
                    sum_next   = (op_reg == kpc_pkg::OP_ADD) ? sum_plus : sum_minus;
                    entry_next = '0;
                    show_next  = 1'b1;
                end
            end
            kpc_pkg::KIND_CLEAR_ALL:
            begin
                entry_next = '0;
                show_next  = 1'b0;
                sum_next   = '0;
                count_next = '0;
            end
            kpc_pkg::KIND_CLEAR_ENTRY:
            begin
                entry_next = '0;
                show_next  = 1'b0;
                count_next = '0;
            end
            default:
            begin
                // Unknown key: hold everything.
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            phase_reg <= kpc_pkg::PHASE_FIRST;
            op_reg    <= kpc_pkg::OP_NONE;
            show_reg  <= 1'b0;
        end
        else if (adv0)
        begin
            entry_reg <= entry_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            show_reg  <= show_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude of the sum modulo ten thousand.
    // ------------------------------------------------------------------
    kpc_pkg::sum_t  mag;
    kpc_pkg::val_t  rem_mod;
    kpc_pkg::disp_t disp1;
    kpc_pkg::disp_t disp2_reg;
    kpc_pkg::val_t  rem2_reg;

    assign mag = sum_reg[kpc_pkg::SUM_W-1] ? kpc_pkg::sum_t'(-sum_reg) : sum_reg;

    always_comb
    begin
        if (mag >= kpc_pkg::sum_t'(30000))
            rem_mod = kpc_pkg::val_t'(mag - kpc_pkg::sum_t'(30000));
        else if (mag >= kpc_pkg::sum_t'(20000))
            rem_mod = kpc_pkg::val_t'(mag - kpc_pkg::sum_t'(20000));
        else if (mag >= kpc_pkg::sum_t'(10000))
            rem_mod = kpc_pkg::val_t'(mag - kpc_pkg::sum_t'(10000));
        else
            rem_mod = kpc_pkg::val_t'(mag);
    end

    assign disp1.entry    = entry_reg;
    assign disp1.show_sum = show_reg;
    assign disp1.result   = (phase_reg == kpc_pkg::PHASE_RESULT);
    assign disp1.sum      = sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            disp2_reg <= disp1;
            rem2_reg  <= rem_mod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotients by 10, 100 and 1000 through reciprocal multiplies.
    // ------------------------------------------------------------------
    logic [kpc_pkg::PROD_W-1:0] p10, p100, p1000;
    kpc_pkg::disp_t disp3_reg;
    kpc_pkg::val_t  rem3_reg;
    logic [9:0]     q10_reg;
    logic [6:0]     q100_reg;
    logic [3:0]     q1000_reg;

    assign p10   = kpc_pkg::PROD_W'(rem2_reg) * kpc_pkg::PROD_W'(kpc_pkg::RECIP_10);
    assign p100  = kpc_pkg::PROD_W'(rem2_reg) * kpc_pkg::PROD_W'(kpc_pkg::RECIP_100);
    assign p1000 = kpc_pkg::PROD_W'(rem2_reg) * kpc_pkg::PROD_W'(kpc_pkg::RECIP_1000);

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            disp3_reg <= disp2_reg;
            rem3_reg  <= rem2_reg;
            q10_reg   <= 10'(p10 >> kpc_pkg::RECIP_SHIFT);
            q100_reg  <= 7'(p100 >> kpc_pkg::RECIP_SHIFT);
            q1000_reg <= 4'(p1000 >> kpc_pkg::RECIP_SHIFT_1000);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: digits from quotient differences, then pick entry or sum.
    // ------------------------------------------------------------------
    kpc_pkg::val_t   ten_q10, ten_q100, ten_q1000;
    kpc_pkg::digit_t sum_ones, sum_tens, sum_hundreds;
    kpc_pkg::digit_t ones_reg, tens_reg, hundreds_reg, thousands_reg;
    logic            neg_reg, result_reg;
    kpc_pkg::sum_t   acc_reg;

    assign ten_q10   = kpc_pkg::val_t'(q10_reg) * kpc_pkg::val_t'(10);
    assign ten_q100  = kpc_pkg::val_t'(q100_reg) * kpc_pkg::val_t'(10);
    assign ten_q1000 = kpc_pkg::val_t'(q1000_reg) * kpc_pkg::val_t'(10);

    assign sum_ones     = kpc_pkg::digit_t'(rem3_reg - ten_q10);
    assign sum_tens     = kpc_pkg::digit_t'(kpc_pkg::val_t'(q10_reg) - ten_q100);
    assign sum_hundreds = kpc_pkg::digit_t'(kpc_pkg::val_t'(q100_reg) - ten_q1000);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            if (disp3_reg.show_sum)
            begin
                ones_reg      <= sum_ones;
                tens_reg      <= sum_tens;
                hundreds_reg  <= sum_hundreds;
                thousands_reg <= q1000_reg;
            end
            else
            begin
                ones_reg      <= disp3_reg.entry[0];
                tens_reg      <= disp3_reg.entry[1];
                hundreds_reg  <= disp3_reg.entry[2];
                thousands_reg <= disp3_reg.entry[3];
            end
            // The sign flag only survives while the sum is on display.
            neg_reg    <= disp3_reg.show_sum && disp3_reg.sum[kpc_pkg::SUM_W-1];
            result_reg <= disp3_reg.result;
            acc_reg    <= disp3_reg.sum;
        end
    end

    // Valid bits: advance on the ready chain, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                vout_reg <= v3_reg;
        end
    end

    assign out_valid       = vout_reg;
    assign shown_ones      = ones_reg;
    assign shown_tens      = tens_reg;
    assign shown_hundreds  = hundreds_reg;
    assign shown_thousands = thousands_reg;
    assign shown_negative  = neg_reg;
    assign showing_result  = result_reg;
    assign accumulator     = $signed(acc_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The sum is only ever on display in result phase.
    a_show_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        show_reg |-> (phase_reg == kpc_pkg::PHASE_RESULT))
        else $error("sum display outside result phase");

    // Entry digits stay decimal.
    a_entry_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_reg[0] <= 4'd9) && (entry_reg[1] <= 4'd9) &&
        (entry_reg[2] <= 4'd9) && (entry_reg[3] <= 4'd9))
        else $error("entry digit above nine");

    // The digit count never passes the entry limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kpc_pkg::count_t'(kpc_pkg::DIGIT_COUNT))
        else $error("digit count beyond limit");

    // Every displayed digit, including those split from the sum, is decimal.
    a_out_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((shown_ones <= 4'd9) && (shown_tens <= 4'd9) &&
                       (shown_hundreds <= 4'd9) && (shown_thousands <= 4'd9)))
        else $error("displayed digit above nine");

    // A negative sign is shown only with a result.
    a_neg_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shown_negative) |-> showing_result)
        else $error("sign flag without result");

endmodule

`default_nettype wire
